// File: design/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

   localparam int OPERAND_BITS = 16;
   localparam int CNT_BITS     = $clog2(OPERAND_BITS);

   typedef logic [OPERAND_BITS-1:0] opnd_type;
   typedef logic [OPERAND_BITS:0]   mod_type;
   typedef logic [CNT_BITS-1:0]     cnt_type;

   localparam cnt_type BIT_TOP = cnt_type'(OPERAND_BITS - 1);

   typedef enum logic [0:0] {
      REG_EXPONENT = 1'b0,
      REG_MODULUS  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic    load;
      logic    step_reduce;
      logic    end_reduce;
      logic    step_mul;
      logic    commit;
      logic    out_load;
      cnt_type bit_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic exp_zero;
   } dp_status_type;

   // one doubling and one addition, each followed by a conditional subtract
   function automatic opnd_type mod_step(input opnd_type acc, input opnd_type addend,
                                         input mod_type m);
      logic [OPERAND_BITS+1:0] t;
      logic [OPERAND_BITS+1:0] mm;
      mm = {1'b0, m};
      t  = {1'b0, acc, 1'b0};
      if (t >= mm) begin
         t = t - mm;
      end
      t = t + {2'b00, addend};
      if (t >= mm) begin
         t = t - mm;
      end
      return t[OPERAND_BITS-1:0];
   endfunction

endpackage

// File: design/mexp_if.sv
`timescale 1ns / 1ps

interface mexp_req_if;
   logic                       valid;
   logic                       ready;
   logic [mexp_pkg::OPERAND_BITS-1:0] base_value;
   modport source (output valid, output base_value, input ready);
   modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mexp_pkg::OPERAND_BITS-1:0] power_result;
   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);
endinterface

interface mexp_csr_if;
   logic                       valid;
   logic                       ready;
   mexp_pkg::csr_index_type    index;
   logic [mexp_pkg::OPERAND_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/mexp_datapath.sv
`timescale 1ns / 1ps

module mexp_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mexp_pkg::dp_cmd_type              cmd,
   output mexp_pkg::dp_status_type           status,
   input  logic [mexp_pkg::OPERAND_BITS-1:0] base_value,
   input  logic                              csr_write,
   input  mexp_pkg::csr_index_type           csr_index,
   input  logic [mexp_pkg::OPERAND_BITS-1:0] csr_data,
   output logic [mexp_pkg::OPERAND_BITS-1:0] power_result
);
   import mexp_pkg::*;

   opnd_type cfg_exp_ff;
   opnd_type cfg_mod_ff;
   opnd_type exp_ff;
   mod_type  mod_ff;
   opnd_type base_ff;
   opnd_type r_ff;
   opnd_type acc_r_ff;
   opnd_type acc_b_ff;
   opnd_type out_ff;

   opnd_type acc_r_cur;
   opnd_type acc_b_cur;
   opnd_type acc_r_in;
   opnd_type acc_b_in;
   logic     first;
   logic     base_bit;

   // accumulators start from zero on the first bit of each pass
   assign first     = (cmd.bit_idx == BIT_TOP);
   assign acc_r_cur = first ? '0 : acc_r_ff;
   assign acc_b_cur = first ? '0 : acc_b_ff;
   assign base_bit  = base_ff[cmd.bit_idx];

   always_comb begin
      if (cmd.step_reduce) begin
         acc_b_in = mod_step(acc_b_cur, opnd_type'(base_bit), mod_ff);
      end else begin
         acc_b_in = mod_step(acc_b_cur, base_bit ? base_ff : '0, mod_ff);
      end
      acc_r_in = mod_step(acc_r_cur, base_bit ? r_ff : '0, mod_ff);
   end

   assign status.exp_zero = (exp_ff == '0);
   assign power_result    = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_exp_ff <= opnd_type'(1);
         cfg_mod_ff <= '1;
      end else if (csr_write) begin
         case (csr_index)
            REG_EXPONENT: cfg_exp_ff <= csr_data;
            REG_MODULUS:  cfg_mod_ff <= csr_data;
            default:      cfg_exp_ff <= cfg_exp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= base_value;
         exp_ff  <= cfg_exp_ff;
         r_ff    <= opnd_type'(1);
         // a modulus of zero stands for two to the operand width
         mod_ff  <= (cfg_mod_ff == '0) ? {1'b1, {OPERAND_BITS{1'b0}}} : {1'b0, cfg_mod_ff};
      end
      if (cmd.step_reduce || cmd.step_mul) begin
         acc_b_ff <= acc_b_in;
      end
      if (cmd.step_mul) begin
         acc_r_ff <= acc_r_in;
      end
      if (cmd.end_reduce) begin
         base_ff <= acc_b_in;
         r_ff    <= (mod_ff == mod_type'(1)) ? '0 : opnd_type'(1);
      end
      if (cmd.commit) begin
         if (exp_ff[0]) begin
            r_ff <= acc_r_in;
         end
         base_ff <= acc_b_in;
         exp_ff  <= exp_ff >> 1;
      end
      if (cmd.out_load) begin
         out_ff <= r_ff;
      end
   end

endmodule

// File: design/mexp_controller.sv
`timescale 1ns / 1ps

module mexp_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mexp_pkg::dp_status_type status,
   output mexp_pkg::dp_cmd_type    cmd
);
   import mexp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   cnt_type   cnt_ff;
   cnt_type   cnt_in;
   logic      out_valid_ff;
   logic      out_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.bit_idx  = cnt_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
               cnt_in   = BIT_TOP;
            end
         end
         ST_REDUCE: begin
            // zero exponent answers 1 without any reduction
            if (cnt_ff == BIT_TOP && status.exp_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step_reduce = 1'b1;
               if (cnt_ff == '0) begin
                  cmd.end_reduce = 1'b1;
                  state_in       = ST_MUL;
                  cnt_in         = BIT_TOP;
               end else begin
                  cnt_in = cnt_ff - cnt_type'(1);
               end
            end
         end
         ST_MUL: begin
            // stop once no set exponent bit remains
            if (cnt_ff == BIT_TOP && status.exp_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step_mul = 1'b1;
               if (cnt_ff == '0) begin
                  cmd.commit = 1'b1;
                  cnt_in     = BIT_TOP;
               end else begin
                  cnt_in = cnt_ff - cnt_type'(1);
               end
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_REDUCE && cnt_ff == BIT_TOP)
      else $error("accepted item did not start reduction");

   a_reduce_to_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REDUCE && cnt_ff == '0 |=> state_ff == ST_MUL && cnt_ff == BIT_TOP)
      else $error("reduction pass did not hand over to multiply");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && (!out_valid_ff || rsp_ready) |=>
         out_valid_ff && state_ff == ST_IDLE)
      else $error("finished item not moved to output register");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && out_valid_ff && !rsp_ready |=> state_ff == ST_FINISH)
      else $error("finished item dropped while output held");

endmodule

// File: design/modular_exponentiation_unit.sv
`timescale 1ns / 1ps

// Modular exponentiation: power_result = base_value ^ exponent mod modulus.
// Channels: req carries one base_value per item, rsp returns one power_result
// per item, csr writes the exponent (index 0) and modulus (index 1). The csr
// channel is always ready; the user must write it only while no item is in
// flight, and the block itself does not enforce this. Each item is processed
// on its own: one modular step unit first reduces the base, one bit of the
// operand per cycle, then two such units do the square and the optional
// multiply of each exponent bit in parallel at the same rate. Work stops
// after the highest set exponent bit. The next item is accepted in the cycle
// after the result enters the output register, so a stalled receiver holds
// one finished result while the next item is computed; that item then waits
// until the output register drains.
// Reset clears the controller and sets exponent to 1 and modulus to all ones.

module modular_exponentiation_unit (
   input logic        clock,
   input logic        reset,
   mexp_req_if.sink   req,
   mexp_rsp_if.source rsp,
   mexp_csr_if.sink   csr
);
   import mexp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr.ready = 1'b1;

   mexp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mexp_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .base_value   (req.base_value),
      .csr_write    (csr.valid && csr.ready),
      .csr_index    (csr.index),
      .csr_data     (csr.data),
      .power_result (rsp.power_result)
   );

endmodule
